### hdl/pwsw_pkg.sv
// Package for the pulse-width single-wire receiver.
// Holds the transaction structs, command codes and register indexes; no dependencies.
`default_nettype none

package pwsw_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] REG_START_LOW_MIN = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_START_LOW_MAX = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_PULSE_MIN     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_PULSE_MID     = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_PULSE_MAX     = 3'd4;

	localparam logic [CfgDataW-1:0] RST_START_LOW_MIN = 16'd3600;
	localparam logic [CfgDataW-1:0] RST_START_LOW_MAX = 16'd4400;
	localparam logic [CfgDataW-1:0] RST_PULSE_MIN     = 16'd40;
	localparam logic [CfgDataW-1:0] RST_PULSE_MID     = 16'd120;
	localparam logic [CfgDataW-1:0] RST_PULSE_MAX     = 16'd200;

	localparam logic [1:0] CMD_EDGE     = 2'd0;
	localparam logic [1:0] CMD_OVERFLOW = 2'd1;
	localparam logic [1:0] CMD_WAKE     = 2'd2;

	localparam int unsigned BitPosW = 3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] duration;
	} pwsw_in_t;

	typedef struct packed {
		logic       armed_rising;
		logic       waiting_start;
		logic       receiving;
		logic       byte_done;
		logic [7:0] byte_value;
		logic [3:0] byte_index;
		logic       frame_abort;
		logic       overflow;
	} pwsw_out_t;

endpackage

`default_nettype wire

### hdl/pulse_width_single_wire_receiver_unit.sv
// Top level of the pulse-width single-wire receiver: input register, decode, result register.
// Depends on pwsw_pkg.
`default_nettype none

// Decodes one edge, overflow or wake transaction per cycle while the result output
// is not stalled. A transaction is registered in the input register on acceptance
// and its result in the result register that drives result_valid; the receiver
// state is updated along with the result register. A stalled result output backs up
// into the input register and then into item_ready. Timing registers are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while no transaction
// is in flight (the block does not enforce this); indexes past the last register are ignored.
module pulse_width_single_wire_receiver_unit import pwsw_pkg::*; #(
	parameter int unsigned MAX_BYTES = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire pwsw_in_t            item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output pwsw_out_t                result
);

	localparam int unsigned CntW = $clog2(MAX_BYTES + 1);
	localparam logic [CntW-1:0] CntMax = CntW'(MAX_BYTES);

	logic [CfgDataW-1:0] start_low_min_q, start_low_max_q;
	logic [CfgDataW-1:0] pulse_min_q, pulse_mid_q, pulse_max_q;

	logic              valid_s1;
	pwsw_in_t          item_s1;
	logic              valid_s2;
	pwsw_out_t         result_s2;

	logic              start_pending_q, frame_active_q, wake_pending_q, edge_rising_q;
	logic [15:0]       last_high_q;
	logic [BitPosW-1:0] bit_pos_q;
	logic [CntW-1:0]   byte_count_q;
	logic [7:0]        shift_q;

	logic              start_pending_d, frame_active_d, wake_pending_d, edge_rising_d;
	logic [15:0]       last_high_d;
	logic [BitPosW-1:0] bit_pos_d;
	logic [CntW-1:0]   byte_count_d;
	logic [7:0]        shift_d;
	pwsw_out_t         res_d;
	logic [CntW+3:0]   cnt_ext;

	logic              advance;
	logic              bit_zero, bit_one, high_ok, start_ok;
	logic [15:0]       dur;

	assign advance = !valid_s2 || result_ready;
	assign item_ready = !valid_s1 || advance;
	assign result_valid = valid_s2;
	assign result = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_low_min_q <= RST_START_LOW_MIN;
			start_low_max_q <= RST_START_LOW_MAX;
			pulse_min_q <= RST_PULSE_MIN;
			pulse_mid_q <= RST_PULSE_MID;
			pulse_max_q <= RST_PULSE_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_LOW_MIN: start_low_min_q <= cfg_data;
				REG_START_LOW_MAX: start_low_max_q <= cfg_data;
				REG_PULSE_MIN:     pulse_min_q <= cfg_data;
				REG_PULSE_MID:     pulse_mid_q <= cfg_data;
				REG_PULSE_MAX:     pulse_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dur = item_s1.duration;
	assign high_ok = (dur > pulse_min_q) && (dur < pulse_max_q);
	assign start_ok = !(dur < start_low_min_q) && !(dur > start_low_max_q);
	assign bit_zero = (last_high_q < pulse_mid_q) && (last_high_q > pulse_min_q)
		&& (dur < pulse_max_q) && (dur > pulse_mid_q);
	assign bit_one = (last_high_q > pulse_mid_q) && (last_high_q < pulse_max_q)
		&& (dur < pulse_mid_q) && (dur > pulse_min_q);
	assign cnt_ext = {4'd0, byte_count_q};

	always_comb begin
		start_pending_d = start_pending_q;
		frame_active_d = frame_active_q;
		wake_pending_d = wake_pending_q;
		edge_rising_d = edge_rising_q;
		last_high_d = last_high_q;
		bit_pos_d = bit_pos_q;
		byte_count_d = byte_count_q;
		shift_d = shift_q;
		res_d = '0;
		unique case (item_s1.cmd)
			CMD_EDGE: begin
				if (!edge_rising_q) begin
					if (!frame_active_q && !start_pending_q) begin
						start_pending_d = 1'b1;
						edge_rising_d = 1'b1;
					end else if (start_pending_q && frame_active_q) begin
						if (high_ok) begin
							last_high_d = dur;
							edge_rising_d = 1'b1;
						end else begin
							last_high_d = '0;
							start_pending_d = 1'b0;
							frame_active_d = 1'b0;
							res_d.frame_abort = 1'b1;
						end
					end
				end else begin
					if (start_pending_q && !frame_active_q) begin
						if (start_ok) begin
							frame_active_d = 1'b1;
							bit_pos_d = '0;
							byte_count_d = '0;
							shift_d = '0;
						end else begin
							start_pending_d = 1'b0;
							frame_active_d = 1'b0;
							res_d.frame_abort = 1'b1;
						end
					end else if (start_pending_q && frame_active_q) begin
						if (bit_zero || bit_one) begin
							shift_d[bit_pos_q] = bit_one;
							bit_pos_d = bit_pos_q + 1'b1;
							if (bit_pos_q == '1) begin
								if (byte_count_q < CntMax) begin
									res_d.byte_done = 1'b1;
									res_d.byte_value = shift_d;
									res_d.byte_index = cnt_ext[3:0];
									byte_count_d = byte_count_q + 1'b1;
								end else begin
									res_d.overflow = 1'b1;
								end
							end
						end else begin
							start_pending_d = 1'b0;
							frame_active_d = 1'b0;
							res_d.frame_abort = 1'b1;
						end
					end
					edge_rising_d = 1'b0;
				end
			end
			CMD_OVERFLOW: begin
				if (start_pending_q) begin
					frame_active_d = 1'b0;
					res_d.frame_abort = 1'b1;
					start_pending_d = wake_pending_q;
					edge_rising_d = wake_pending_q;
					wake_pending_d = 1'b0;
				end
			end
			CMD_WAKE: begin
				wake_pending_d = 1'b1;
				start_pending_d = 1'b1;
			end
			default: ;
		endcase
		res_d.armed_rising = edge_rising_d;
		res_d.waiting_start = start_pending_d;
		res_d.receiving = frame_active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			start_pending_q <= 1'b0;
			frame_active_q <= 1'b0;
			wake_pending_q <= 1'b0;
			edge_rising_q <= 1'b0;
			last_high_q <= '0;
			bit_pos_q <= '0;
			byte_count_q <= '0;
			shift_q <= '0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (advance && valid_s1) begin
				start_pending_q <= start_pending_d;
				frame_active_q <= frame_active_d;
				wake_pending_q <= wake_pending_d;
				edge_rising_q <= edge_rising_d;
				last_high_q <= last_high_d;
				bit_pos_q <= bit_pos_d;
				byte_count_q <= byte_count_d;
				shift_q <= shift_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
		if (advance && valid_s1) begin
			result_s2 <= res_d;
		end
	end

endmodule

`default_nettype wire

### hdl/pwsw_checker.sv
// Port-level checks for the pulse-width single-wire receiver, bound to the top level.
// Depends on pwsw_pkg and pulse_width_single_wire_receiver_unit.
`default_nettype none

module pwsw_checker import pwsw_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      result_valid,
	input wire logic      result_ready,
	input wire pwsw_out_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result transaction changed while stalled");

	a_receiving_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.receiving |-> result.waiting_start)
		else $error("receiving without start pending");

	a_abort_clears_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_abort |-> !result.receiving && !result.byte_done
		&& !result.overflow)
		else $error("abort transaction still shows frame activity");

	a_byte_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.byte_done |-> result.byte_value == 8'd0
		&& result.byte_index == 4'd0)
		else $error("byte fields set without a completed byte");

	a_byte_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.byte_done || result.overflow) |-> result.receiving
		&& !(result.byte_done && result.overflow))
		else $error("byte completion outside an active frame");

endmodule

bind pulse_width_single_wire_receiver_unit pwsw_checker u_pwsw_checker (
	.clk(clk),
	.arst_n(arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result)
);

`default_nettype wire

### tb/sv/tb_pulse_width_single_wire_receiver_unit.sv
// Testbench for pulse_width_single_wire_receiver_unit: directed and random edge/overflow/wake
// traffic, checked against an in-bench decoder model. Depends on pwsw_pkg and the RTL top.
`timescale 1ns / 100ps

module tb_pulse_width_single_wire_receiver_unit;
	import pwsw_pkg::*;

	localparam int BYTE_LIMIT = 16;
	localparam int STALL_LEN = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam logic [CfgIdxW-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_SPARE_LAST = 3'd7;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic item_valid;
	logic item_ready;
	pwsw_in_t item;
	logic result_valid;
	logic result_ready;
	pwsw_out_t result;

	// decoder model state and timing registers
	logic [15:0] t_start_min = RST_START_LOW_MIN;
	logic [15:0] t_start_max = RST_START_LOW_MAX;
	logic [15:0] t_pulse_min = RST_PULSE_MIN;
	logic [15:0] t_pulse_mid = RST_PULSE_MID;
	logic [15:0] t_pulse_max = RST_PULSE_MAX;
	logic pend_start = 1'b0;
	logic in_frame = 1'b0;
	logic wake_seen = 1'b0;
	logic arm_rise = 1'b0;
	logic [15:0] high_ticks = '0;
	logic [2:0] bit_pos = '0;
	logic [4:0] bytes_stored = '0;
	logic [7:0] shifter = '0;

	pwsw_out_t status_due[$];
	pwsw_out_t want;
	int error_count = 0;
	int events_sent = 0;
	int timing_loads = 0;
	int bytes_seen = 0;
	int aborts_seen = 0;
	int drops_seen = 0;
	int quiet_cycles = 0;
	bit gaps_on = 1'b0;
	bit stall_request = 1'b0;

	pulse_width_single_wire_receiver_unit #(.MAX_BYTES(BYTE_LIMIT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic pwsw_out_t decode_event(input pwsw_in_t ev);
		pwsw_out_t r;
		logic [15:0] d;
		logic [15:0] h;
		logic is_zero;
		logic is_one;
		r = '0;
		d = ev.duration;
		case (ev.cmd)
		CMD_EDGE: begin
			if (!arm_rise) begin
				if (!in_frame && !pend_start) begin
					pend_start = 1'b1;
					arm_rise = 1'b1;
				end else if (pend_start && in_frame) begin
					high_ticks = d;
					if (d > t_pulse_min && d < t_pulse_max) begin
						arm_rise = 1'b1;
					end else begin
						pend_start = 1'b0;
						in_frame = 1'b0;
						high_ticks = '0;
						r.frame_abort = 1'b1;
					end
				end
			end else begin
				h = high_ticks;
				if (pend_start && !in_frame) begin
					if (d < t_start_min || d > t_start_max) begin
						pend_start = 1'b0;
						r.frame_abort = 1'b1;
					end else begin
						in_frame = 1'b1;
						bit_pos = '0;
						bytes_stored = '0;
						shifter = '0;
					end
				end else if (pend_start && in_frame) begin
					is_zero = h > t_pulse_min && h < t_pulse_mid && d > t_pulse_mid && d < t_pulse_max;
					is_one = h > t_pulse_mid && h < t_pulse_max && d > t_pulse_min && d < t_pulse_mid;
					if (is_zero || is_one) begin
						shifter[bit_pos] = is_one;
						bit_pos = bit_pos + 3'd1;
						if (bit_pos == 3'd0) begin
							if (bytes_stored < BYTE_LIMIT) begin
								r.byte_done = 1'b1;
								r.byte_value = shifter;
								r.byte_index = bytes_stored[3:0];
								bytes_stored = bytes_stored + 5'd1;
							end else begin
								r.overflow = 1'b1;
							end
						end
					end else begin
						pend_start = 1'b0;
						in_frame = 1'b0;
						r.frame_abort = 1'b1;
					end
				end
				arm_rise = 1'b0;
			end
		end
		CMD_OVERFLOW: begin
			if (pend_start) begin
				pend_start = 1'b0;
				in_frame = 1'b0;
				arm_rise = 1'b0;
				r.frame_abort = 1'b1;
				if (wake_seen) begin
					pend_start = 1'b1;
					wake_seen = 1'b0;
					arm_rise = 1'b1;
				end
			end
		end
		CMD_WAKE: begin
			wake_seen = 1'b1;
			pend_start = 1'b1;
		end
		default: ;
		endcase
		r.armed_rising = arm_rise;
		r.waiting_start = pend_start;
		r.receiving = in_frame;
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// value strictly inside (lo, hi), random when the window is empty
	function automatic logic [15:0] pick_open(input int lo, input int hi);
		if (hi - lo >= 2)
			return 16'($urandom_range(hi - 1, lo + 1));
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] noise_duration();
		int base;
		if ($urandom_range(0, 1) == 0)
			return 16'($urandom);
		case ($urandom_range(0, 4))
		0: base = int'(t_start_min);
		1: base = int'(t_start_max);
		2: base = int'(t_pulse_min);
		3: base = int'(t_pulse_mid);
		default: base = int'(t_pulse_max);
		endcase
		return 16'(base + $urandom_range(0, 2) - 1);
	endfunction

	function automatic logic [15:0] start_low();
		if (t_start_max >= t_start_min)
			return 16'($urandom_range(t_start_max, t_start_min));
		return 16'($urandom);
	endfunction

	function automatic void flag_field(input string field, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		error_count++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, got_v);
	endfunction

	// sender: valid stays up after acceptance only if the next transaction follows at once
	task automatic send_event(input pwsw_in_t ev);
		int gap;
		gap = gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= ev;
		item_valid <= 1'b1;
		do @(negedge clk); while (item_ready !== 1'b1);
		@(posedge clk);
		status_due.push_back(decode_event(ev));
		events_sent++;
	endtask

	task automatic send_capture(input logic [15:0] d);
		send_event(pwsw_in_t'{cmd: CMD_EDGE, duration: d});
	endtask

	task automatic send_cmd(input logic [1:0] c);
		send_event(pwsw_in_t'{cmd: c, duration: 16'($urandom)});
	endtask

	task automatic send_byte(input logic [7:0] value, input bit noisy);
		logic b;
		for (int i = 0; i < 8; i++) begin
			b = value[i];
			if (noisy && $urandom_range(0, 39) == 0)
				send_capture(noise_duration());
			else
				send_capture(b ? pick_open(int'(t_pulse_mid), int'(t_pulse_max))
					: pick_open(int'(t_pulse_min), int'(t_pulse_mid)));
			send_capture(b ? pick_open(int'(t_pulse_min), int'(t_pulse_mid))
				: pick_open(int'(t_pulse_mid), int'(t_pulse_max)));
		end
	endtask

	task automatic open_frame(input bit via_wake);
		while (pend_start || arm_rise) begin
			if (pend_start)
				send_cmd(CMD_OVERFLOW);
			else
				send_capture(16'($urandom));
		end
		if (via_wake) begin
			send_cmd(CMD_WAKE);
			send_cmd(CMD_OVERFLOW);
		end else begin
			send_capture(16'($urandom));
		end
		send_capture(start_low());
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic load_timing(input logic [15:0] smin, input logic [15:0] smax,
			input logic [15:0] pmin, input logic [15:0] pmid, input logic [15:0] pmax);
		wait_idle();
		put_reg(REG_START_LOW_MIN, smin);
		put_reg(REG_START_LOW_MAX, smax);
		put_reg(REG_PULSE_MIN, pmin);
		put_reg(REG_PULSE_MID, pmid);
		put_reg(REG_PULSE_MAX, pmax);
		put_reg(CfgIdxW'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)), 16'($urandom));
		@(posedge clk);
		cfg_we <= 1'b0;
		t_start_min = smin;
		t_start_max = smax;
		t_pulse_min = pmin;
		t_pulse_mid = pmid;
		t_pulse_max = pmax;
		timing_loads++;
	endtask

	task automatic run_frames(input int budget);
		int stop_at;
		stop_at = events_sent + budget;
		while (events_sent < stop_at) begin
			if ($urandom_range(0, 9) < 7) begin
				open_frame($urandom_range(0, 3) == 0);
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b1);
				case ($urandom_range(0, 3))
				0, 1: send_cmd(CMD_OVERFLOW);
				2: begin
					send_cmd(CMD_WAKE);
					send_cmd(CMD_OVERFLOW);
				end
				default: ;
				endcase
			end else begin
				repeat ($urandom_range(1, 6))
					send_event(pwsw_in_t'{cmd: 2'($urandom), duration: noise_duration()});
			end
		end
	endtask

	task automatic test_idle_events();
		send_event(pwsw_in_t'{cmd: CMD_OVERFLOW, duration: 16'hFFFF});
		send_event(pwsw_in_t'{cmd: CMD_SPARE, duration: 16'hFFFF});
	endtask

	task automatic test_start_window();
		send_capture(16'd0);
		send_capture(RST_START_LOW_MIN - 16'd1);
		send_capture(16'hFFFF);
		send_capture(RST_START_LOW_MIN);
		send_cmd(CMD_OVERFLOW);
		send_capture(16'd0);
		send_capture(RST_START_LOW_MAX + 16'd1);
		send_capture(16'd0);
		send_capture(RST_START_LOW_MAX);
	endtask

	task automatic test_bit_decode();
		send_capture(16'd0);
		send_capture(16'd4000);
		send_capture(RST_PULSE_MIN + 16'd1);
		send_capture(RST_PULSE_MAX - 16'd1);
		send_capture(RST_PULSE_MAX - 16'd1);
		send_capture(RST_PULSE_MIN + 16'd1);
		send_capture(RST_PULSE_MID - 16'd1);
		send_capture(RST_PULSE_MID + 16'd1);
		send_capture(RST_PULSE_MID + 16'd1);
		send_capture(RST_PULSE_MID - 16'd1);
		send_capture(RST_PULSE_MIN);
		send_capture(16'd0);
		send_capture(16'd4000);
		send_capture(RST_PULSE_MID);
		send_capture(16'd100);
	endtask

	task automatic test_wake_restart();
		send_cmd(CMD_WAKE);
		send_capture(16'hFFFF);
		send_cmd(CMD_OVERFLOW);
		send_capture(16'd4000);
		send_capture(RST_PULSE_MAX);
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		stall_request = 1'b1;
		open_frame(1'b0);
		repeat (4) send_byte(8'($urandom), 1'b0);
		send_cmd(CMD_OVERFLOW);
	endtask

	task automatic test_long_frame();
		gaps_on = 1'b1;
		open_frame(1'b0);
		repeat (BYTE_LIMIT + 2) send_byte(8'($urandom), 1'b0);
		send_cmd(CMD_OVERFLOW);
	endtask

	task automatic test_timing_sweep();
		int pmin;
		int pmid;
		int pmax;
		int smin;
		load_timing(16'd0, 16'hFFFF, 16'd0, 16'h8000, 16'hFFFF);
		run_frames(100);
		gaps_on = 1'b0;
		load_timing(16'd1000, 16'd1000, 16'd10, 16'd12, 16'd14);
		run_frames(100);
		gaps_on = 1'b1;
		load_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_frames(25);
		load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_frames(25);
		load_timing(16'd5000, 16'd4000, RST_PULSE_MIN, RST_PULSE_MID, RST_PULSE_MAX);
		run_frames(20);
		for (int k = 0; k < 3; k++) begin
			pmin = $urandom_range(0, 300);
			pmid = pmin + $urandom_range(2, 400);
			pmax = pmid + $urandom_range(2, 400);
			smin = $urandom_range(0, 60000);
			gaps_on = (k != 1);
			load_timing(16'(smin), 16'(smin + $urandom_range(0, 5000)), 16'(pmin),
				16'(pmid), 16'(pmax));
			run_frames(60);
		end
	endtask

	// result side ready: random, long holds now and then, always ready while gaps are off, forced hold on request
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_request) begin
				result_ready <= 1'b0;
				repeat (STALL_LEN) @(posedge clk);
				stall_request = 1'b0;
				result_ready <= 1'b1;
			end else if (!gaps_on) begin
				result_ready <= 1'b1;
			end else if ($urandom_range(0, 99) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(posedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_ready) begin
			if (status_due.size() == 0) begin
				error_count++;
				$display("%0t: unexpected status, expected none, actual %h", $time, result);
			end else begin
				want = status_due.pop_front();
				if (result.armed_rising !== want.armed_rising)
					flag_field("armed_rising", 8'(want.armed_rising),
						8'(result.armed_rising));
				if (result.waiting_start !== want.waiting_start)
					flag_field("waiting_start", 8'(want.waiting_start),
						8'(result.waiting_start));
				if (result.receiving !== want.receiving)
					flag_field("receiving", 8'(want.receiving), 8'(result.receiving));
				if (result.byte_done !== want.byte_done)
					flag_field("byte_done", 8'(want.byte_done), 8'(result.byte_done));
				if (result.byte_value !== want.byte_value)
					flag_field("byte_value", want.byte_value, result.byte_value);
				if (result.byte_index !== want.byte_index)
					flag_field("byte_index", 8'(want.byte_index), 8'(result.byte_index));
				if (result.frame_abort !== want.frame_abort)
					flag_field("frame_abort", 8'(want.frame_abort), 8'(result.frame_abort));
				if (result.overflow !== want.overflow)
					flag_field("overflow", 8'(want.overflow), 8'(result.overflow));
			end
			bytes_seen += int'(result.byte_done === 1'b1);
			aborts_seen += int'(result.frame_abort === 1'b1);
			drops_seen += int'(result.overflow === 1'b1);
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (item_valid && item_ready === 1'b1) ||
				(result_valid === 1'b1 && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("tb_pulse_width_single_wire_receiver_unit failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		item = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gaps_on = 1'b1;
		test_idle_events();
		test_start_window();
		test_bit_decode();
		test_wake_restart();
		test_backpressure();
		test_long_frame();
		test_timing_sweep();
		wait_idle();
		$display("Sent %0d transactions over %0d timing loads plus reset values;", events_sent,
			timing_loads);
		$display("saw %0d bytes, %0d aborts and %0d dropped bytes.", bytes_seen, aborts_seen,
			drops_seen);
		if (error_count == 0)
			$display("tb_pulse_width_single_wire_receiver_unit passed");
		else
			$display("tb_pulse_width_single_wire_receiver_unit failed");
		$finish;
	end

endmodule

### files.f
hdl/pwsw_pkg.sv
hdl/pulse_width_single_wire_receiver_unit.sv
hdl/pwsw_checker.sv
tb/sv/tb_pulse_width_single_wire_receiver_unit.sv
